// ===== design/mst_pkg.sv =====
// Shared types, constants and character-class functions for the markup source tokenizer.
package mst_pkg;

	localparam int POS_BITS = 16;
	localparam int LEN_BITS = 16;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [LEN_BITS-1:0] len_t;

	localparam pos_t POS_MAX = '1;
	localparam pos_t POS_ONE = pos_t'(1);
	localparam len_t LEN_MAX = '1;

	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_IDENT  = 4'd1,
		M_STR    = 4'd2,
		M_SLASH  = 4'd3,
		M_LINEC  = 4'd4,
		M_BLOCK  = 4'd5,
		M_BSTAR  = 4'd6,
		M_GFIRST = 4'd7,
		M_GBODY  = 4'd8
	} mode_t;

	// Word kinds
	localparam logic IK_VALUE  = 1'b0;
	localparam logic IK_RECORD = 1'b1;

	// Token kinds
	localparam logic [4:0] TK_IDENT   = 5'd0;
	localparam logic [4:0] TK_STRING  = 5'd4;
	localparam logic [4:0] TK_LBRACE  = 5'd5;
	localparam logic [4:0] TK_RBRACE  = 5'd6;
	localparam logic [4:0] TK_COLON   = 5'd7;
	localparam logic [4:0] TK_EQUAL   = 5'd8;
	localparam logic [4:0] TK_SEMI    = 5'd9;
	localparam logic [4:0] TK_LBRACK  = 5'd10;
	localparam logic [4:0] TK_RBRACK  = 5'd11;
	localparam logic [4:0] TK_AT      = 5'd12;
	localparam logic [4:0] TK_PLUS    = 5'd13;
	localparam logic [4:0] TK_STAR    = 5'd14;
	localparam logic [4:0] TK_SLASH   = 5'd15;
	localparam logic [4:0] TK_LINEC   = 5'd16;
	localparam logic [4:0] TK_BLOCK   = 5'd17;
	localparam logic [4:0] TK_HASHC   = 5'd18;
	localparam logic [4:0] TK_UNKNOWN = 5'd19;
	localparam logic [4:0] TK_END     = 5'd20;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Keyword table: text left-aligned in eight bytes, lengths per entry
	localparam logic [2:0][63:0] KW_TEXT = {{"as", 48'h0}, {"from", 32'h0}, {"delete", 16'h0}};
	localparam logic [2:0][2:0]  KW_LEN  = {3'd2, 3'd4, 3'd6};

	typedef struct packed {
		pos_t line;
		pos_t col;
	} cursor_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] value_byte;
		logic [4:0] token_kind;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [15:0] token_length;
	} res_t;

	typedef struct packed {
		logic [1:0]     count;
		res_t [2:0]     res;
	} step_t;

	function automatic pos_t sat_pos(pos_t v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic ident_start(logic [7:0] c);
		return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F, 8'h2D, 8'h2E});
	endfunction

	function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] j);
		logic [2:0] pos;
		pos = 3'd7 - j;
		return KW_TEXT[k][{pos, 3'b000} +: 8];
	endfunction

	function automatic logic [4:0] punct_kind(logic [7:0] c);
		logic [4:0] k;
		case (c)
			8'h7B: k = TK_LBRACE;
			8'h7D: k = TK_RBRACE;
			8'h3A: k = TK_COLON;
			8'h3D: k = TK_EQUAL;
			8'h3B: k = TK_SEMI;
			8'h5B: k = TK_LBRACK;
			8'h5D: k = TK_RBRACK;
			8'h40: k = TK_AT;
			8'h2B: k = TK_PLUS;
			CH_STAR: k = TK_STAR;
			default: k = TK_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

// ===== design/mst_lexer.sv =====
// Tokenizer state and single-pass step logic: one byte in, up to three words out.
module mst_lexer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic [7:0]     byte_in,
	output mst_pkg::step_t step
);
	import mst_pkg::*;

	mode_t      mode_q;
	cursor_t    cur_q;
	pos_t       tl_q, tc_q;
	len_t       tlen_q;
	logic [2:0] kw_q;

	mode_t      mode_n;
	cursor_t    cur_n;
	pos_t       tl_n, tc_n;
	len_t       tlen_n;
	logic [2:0] kw_n;

	function automatic cursor_t advance(cursor_t p, logic [7:0] b);
		cursor_t o;
		o = p;
		if (b == CH_LF) begin
			o.line = sat_pos(p.line);
			o.col  = POS_ONE;
		end else begin
			o.col = sat_pos(p.col);
		end
		return o;
	endfunction

	function automatic res_t mk(logic ik, logic [7:0] vb, logic [4:0] tk,
	                            pos_t ln, pos_t cl, len_t len);
		res_t r;
		r.item_kind    = ik;
		r.value_byte   = vb;
		r.token_kind   = tk;
		r.token_line   = 16'(ln);
		r.token_column = 16'(cl);
		r.token_length = 16'(len);
		return r;
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [1:0] n;
		res_t [2:0] r;
		logic       idle, body;
		logic [4:0] bkind, kind;
		c      = byte_in;
		n      = 2'd0;
		r      = '0;
		idle   = 1'b0;
		body   = 1'b0;
		bkind  = TK_LINEC;
		kind   = TK_IDENT;
		mode_n = mode_q;
		cur_n  = cur_q;
		tl_n   = tl_q;
		tc_n   = tc_q;
		tlen_n = tlen_q;
		kw_n   = kw_q;
		case (mode_q)
			M_IDENT: begin
				if (ident_start(c) || c == CH_PCT) begin
					for (int i = 0; i < 3; i++)
						if (!(tlen_n < len_t'(KW_LEN[i]) && kw_char(2'(i), tlen_n[2:0]) == c))
							kw_n[i] = 1'b0;
					r[n] = mk(IK_VALUE, c, TK_IDENT, '0, '0, '0);
					n = n + 2'd1;
					if (tlen_n != LEN_MAX) tlen_n = tlen_n + len_t'(1);
					cur_n = advance(cur_n, c);
				end else begin
					for (int i = 2; i >= 0; i--)
						if (kw_n[i] && tlen_n == len_t'(KW_LEN[i]))
							kind = 5'(i + 1);
					r[n] = mk(IK_RECORD, 8'h00, kind, tl_n, tc_n, tlen_n);
					n = n + 2'd1;
					idle = 1'b1;
				end
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					cur_n = advance(cur_n, c);
					r[n] = mk(IK_RECORD, 8'h00, TK_STRING, tl_n, tc_n, tlen_n);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end else if (c == CH_NUL) begin
					cur_n = advance(cur_n, c);
					r[n] = mk(IK_RECORD, 8'h00, TK_STRING, tl_n, tc_n, tlen_n);
					n = n + 2'd1;
					idle = 1'b1;
				end else begin
					r[n] = mk(IK_VALUE, c, TK_IDENT, '0, '0, '0);
					n = n + 2'd1;
					if (tlen_n != LEN_MAX) tlen_n = tlen_n + len_t'(1);
					cur_n = advance(cur_n, c);
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					cur_n = advance(cur_n, c);
					mode_n = M_LINEC;
				end else if (c == CH_STAR) begin
					cur_n = advance(cur_n, c);
					mode_n = M_BLOCK;
				end else begin
					r[n] = mk(IK_RECORD, CH_SLASH, TK_SLASH, tl_n, tc_n, len_t'(1));
					n = n + 2'd1;
					idle = 1'b1;
				end
			end
			M_LINEC: begin
				body = 1'b1;
				bkind = TK_LINEC;
			end
			M_GFIRST: begin
				mode_n = M_GBODY;
				if (c == CH_SPACE) begin
					cur_n = advance(cur_n, c);
				end else begin
					body = 1'b1;
					bkind = TK_HASHC;
				end
			end
			M_GBODY: begin
				body = 1'b1;
				bkind = TK_HASHC;
			end
			M_BLOCK, M_BSTAR: begin
				if (mode_q == M_BSTAR && c == CH_SLASH) begin
					cur_n = advance(cur_n, c);
					r[n] = mk(IK_RECORD, 8'h00, TK_BLOCK, tl_n, tc_n, tlen_n);
					n = n + 2'd1;
					mode_n = M_IDLE;
				end else begin
					if (mode_q == M_BSTAR) begin
						r[n] = mk(IK_VALUE, CH_STAR, TK_IDENT, '0, '0, '0);
						n = n + 2'd1;
						if (tlen_n != LEN_MAX) tlen_n = tlen_n + len_t'(1);
					end
					if (c == CH_NUL) begin
						cur_n = advance(cur_n, c);
						cur_n = advance(cur_n, c);
						r[n] = mk(IK_RECORD, 8'h00, TK_BLOCK, tl_n, tc_n, tlen_n);
						n = n + 2'd1;
						idle = 1'b1;
					end else if (c == CH_STAR) begin
						cur_n = advance(cur_n, c);
						mode_n = M_BSTAR;
					end else begin
						r[n] = mk(IK_VALUE, c, TK_IDENT, '0, '0, '0);
						n = n + 2'd1;
						if (tlen_n != LEN_MAX) tlen_n = tlen_n + len_t'(1);
						cur_n = advance(cur_n, c);
						mode_n = M_BLOCK;
					end
				end
			end
			default: idle = 1'b1;
		endcase

		// comment body: line end or end of input closes it, else take the byte as text
		if (body) begin
			if (c == CH_NUL || c == CH_LF) begin
				r[n] = mk(IK_RECORD, 8'h00, bkind, tl_n, tc_n, tlen_n);
				n = n + 2'd1;
				idle = 1'b1;
			end else begin
				r[n] = mk(IK_VALUE, c, TK_IDENT, '0, '0, '0);
				n = n + 2'd1;
				if (tlen_n != LEN_MAX) tlen_n = tlen_n + len_t'(1);
				cur_n = advance(cur_n, c);
			end
		end

		// fresh byte between tokens
		if (idle) begin
			mode_n = M_IDLE;
			if (c == CH_NUL) begin
				r[n] = mk(IK_RECORD, 8'h00, TK_END, cur_n.line, cur_n.col, '0);
				n = n + 2'd1;
				cur_n  = '{line: POS_ONE, col: POS_ONE};
				tl_n   = POS_ONE;
				tc_n   = POS_ONE;
				tlen_n = '0;
				kw_n   = 3'b111;
			end else if (is_space(c)) begin
				cur_n = advance(cur_n, c);
			end else if (ident_start(c)) begin
				tl_n = cur_n.line;
				tc_n = cur_n.col;
				tlen_n = '0;
				mode_n = M_IDENT;
				kw_n = 3'b111;
				for (int i = 0; i < 3; i++)
					if (kw_char(2'(i), 3'd0) != c) kw_n[i] = 1'b0;
				r[n] = mk(IK_VALUE, c, TK_IDENT, '0, '0, '0);
				n = n + 2'd1;
				tlen_n = len_t'(1);
				cur_n = advance(cur_n, c);
			end else if (c == CH_QUOTE || c == CH_HASH || c == CH_SLASH) begin
				tl_n = cur_n.line;
				tc_n = cur_n.col;
				tlen_n = '0;
				if (c == CH_QUOTE) mode_n = M_STR;
				else if (c == CH_HASH) mode_n = M_GFIRST;
				else mode_n = M_SLASH;
				cur_n = advance(cur_n, c);
			end else begin
				r[n] = mk(IK_RECORD, c, punct_kind(c), cur_n.line, cur_n.col, len_t'(1));
				n = n + 2'd1;
				cur_n = advance(cur_n, c);
			end
		end

		step.count = n;
		step.res   = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cur_q  <= '{line: POS_ONE, col: POS_ONE};
			tl_q   <= POS_ONE;
			tc_q   <= POS_ONE;
			tlen_q <= '0;
			kw_q   <= 3'b111;
		end else if (step_en) begin
			mode_q <= mode_n;
			cur_q  <= cur_n;
			tl_q   <= tl_n;
			tc_q   <= tc_n;
			tlen_q <= tlen_n;
			kw_q   <= kw_n;
		end
	end

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.line != '0 && cur_q.col != '0)
		else $error("cursor position fell to zero");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && byte_in == CH_NUL |=> mode_q == M_IDLE && tlen_q == '0 && kw_q == 3'b111)
		else $error("state not cleared after end of input");

	a_mode_known: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= M_GBODY)
		else $error("tokenizer mode left its legal set");

endmodule

// ===== design/mst_resq.sv =====
// Result bank: holds up to three words of a byte; sends one per cycle unless stalled.
module mst_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  mst_pkg::step_t    step,
	output logic              free,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              item_kind,
	output logic [7:0]        value_byte,
	output logic [4:0]        token_kind,
	output logic [15:0]       token_line,
	output logic [15:0]       token_column,
	output logic [15:0]       token_length,
	output logic              last_of_run
);
	import mst_pkg::*;

	res_t [2:0] res_q;
	logic [1:0] ptr_q;
	logic [1:0] rem_q;
	logic       pop;
	res_t       cur;

	assign result_valid = (rem_q != 2'd0);
	assign pop  = result_valid && !result_stall;
	assign free = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
	assign cur  = res_q[ptr_q];

	assign item_kind    = cur.item_kind;
	assign value_byte   = cur.value_byte;
	assign token_kind   = cur.token_kind;
	assign token_line   = cur.token_line;
	assign token_column = cur.token_column;
	assign token_length = cur.token_length;
	assign last_of_run  = (rem_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= 2'd0;
			rem_q <= 2'd0;
		end else if (load) begin
			ptr_q <= 2'd0;
			rem_q <= step.count;
		end else if (pop) begin
			ptr_q <= ptr_q + 2'd1;
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= step.res;
	end

	a_bank_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ptr_q} + {1'b0, rem_q} <= 3'd3)
		else $error("result bank pointer ran past its entries");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result_valid == ($past(step.count) != 2'd0))
		else $error("loaded words not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> rem_q == 2'd0 || (rem_q == 2'd1 && pop))
		else $error("bank reloaded while words still pending");

endmodule

// ===== design/markup_source_tokenizer.sv =====
// Top level of the markup source tokenizer: input register, step logic and result bank.
//
// Use: feed one source byte per word on the source channel (source_valid,
// source_stall, source_byte); a zero byte ends the source. Words come back on
// the result channel (result_valid, result_stall and the field ports): text
// bytes of a token as value words, then a token record, with last_of_run set
// on the final word caused by each byte.
// A byte accepted on the source channel lands in the input register; once the
// bank has room the step logic processes it, the result bank loads its words
// and the first of them is presented.
// Throughput: one byte per cycle while each byte causes at most one word and
// the receiver does not stall. The result bank sends one word per cycle unless
// stalled, so a byte that causes more than one word (up to three) occupies the
// bank until its last word is sent and holds the input back until then.
// Reset (arst_n low) clears the tokenizer to idle at line 1, column 1 and
// empties both registers. While the receiver stalls, the current word holds;
// once the bank has no room the input register fills and source_stall rises.
module markup_source_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        source_valid,
	output logic        source_stall,
	input  logic [7:0]  source_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        item_kind,
	output logic [7:0]  value_byte,
	output logic [4:0]  token_kind,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic [15:0] token_length,
	output logic        last_of_run
);
	import mst_pkg::*;

	logic [7:0] byte_s1;
	logic       vld_s1;
	logic       free;
	logic       adv;
	step_t      step;

	// advance the held byte whenever the bank can take its words
	assign adv          = vld_s1 && free;
	assign source_stall = vld_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (source_valid && !source_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	// hold the byte until it is processed
	always_ff @(posedge clk) begin
		if (source_valid && !source_stall) byte_s1 <= source_byte;
	end

	mst_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.byte_in (byte_s1),
		.step    (step)
	);

	mst_resq u_resq (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv),
		.step         (step),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.item_kind    (item_kind),
		.value_byte   (value_byte),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_column (token_column),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

endmodule

// ===== sim/tb_markup_source_tokenizer.sv =====
// Self-checking testbench for the markup source tokenizer: directed table and random source text.
module tb_markup_source_tokenizer;
	import mst_pkg::*;

	// Identifier and keyword token kinds; the package names only code 0, as TK_IDENT
	localparam logic [4:0] KIND_NONE   = 5'd0;
	localparam logic [4:0] KIND_DELETE = 5'd1;
	localparam logic [4:0] KIND_FROM   = 5'd2;
	localparam logic [4:0] KIND_AS     = 5'd3;

	localparam int RANDOM_ITEMS    = 230;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 400;
	localparam int MAX_REPORTS     = 40;

	// One result word, all seven fields
	typedef struct packed {
		logic        item_kind;
		logic [7:0]  value_byte;
		logic [4:0]  token_kind;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic [15:0] token_length;
		logic        last_of_run;
	} word_t;

	// A directed row: the source byte, and a hand-written word where one is given
	typedef struct packed {
		logic [7:0] src;
		logic       typed;
		word_t      want;
	} row_t;

	localparam word_t NO_WORD = '0;

	localparam row_t DIRECTED_ROWS [26] = '{
		// first byte after reset: a brace at line 1, column 1
		'{"{", 1'b1, '{IK_RECORD, "{", TK_LBRACE, 16'd1, 16'd1, 16'd1, 1'b1}},
		// top byte value is an unknown token
		'{8'hFF, 1'b1, '{IK_RECORD, 8'hFF, TK_UNKNOWN, 16'd1, 16'd2, 16'd1, 1'b1}},
		// keyword "as", closed by a space
		'{"a", 1'b0, NO_WORD}, '{"s", 1'b0, NO_WORD}, '{CH_SPACE, 1'b0, NO_WORD},
		// pending slash broken by an identifier that carries a percent, ended by LF
		'{CH_SLASH, 1'b0, NO_WORD}, '{"x", 1'b0, NO_WORD}, '{CH_PCT, 1'b0, NO_WORD},
		'{CH_LF, 1'b0, NO_WORD},
		// hash comment with its optional space, ended by LF
		'{CH_HASH, 1'b0, NO_WORD}, '{CH_SPACE, 1'b0, NO_WORD}, '{"q", 1'b0, NO_WORD},
		'{CH_LF, 1'b0, NO_WORD},
		// block comment left open with a star pending at end of input
		'{CH_SLASH, 1'b0, NO_WORD}, '{CH_STAR, 1'b0, NO_WORD}, '{CH_STAR, 1'b0, NO_WORD},
		'{CH_NUL, 1'b0, NO_WORD},
		// percent on its own after the source cleared
		'{CH_PCT, 1'b1, '{IK_RECORD, CH_PCT, TK_UNKNOWN, 16'd1, 16'd1, 16'd1, 1'b1}},
		// string left open with a high byte inside
		'{CH_QUOTE, 1'b0, NO_WORD}, '{8'h80, 1'b0, NO_WORD}, '{CH_NUL, 1'b0, NO_WORD},
		// empty source
		'{CH_NUL, 1'b1, '{IK_RECORD, CH_NUL, TK_END, 16'd1, 16'd1, 16'd0, 1'b1}},
		// identifier cut by a line comment that runs to end of input
		'{"-", 1'b0, NO_WORD}, '{CH_SLASH, 1'b0, NO_WORD}, '{CH_SLASH, 1'b0, NO_WORD},
		'{CH_NUL, 1'b0, NO_WORD}
	};

	localparam logic [7:0] BLANKS [6] = '{CH_SPACE, 8'h09, CH_LF, 8'h0B, 8'h0C, 8'h0D};
	localparam logic [7:0] PUNCT [12] = '{"{", "}", ":", "=", ";", "[", "]", "@", "+", "*",
		"%", "/"};

	string kw_word [3] = '{"delete", "from", "as"};
	localparam logic [4:0] KW_KIND [3] = '{KIND_DELETE, KIND_FROM, KIND_AS};
	string name_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        source_valid;
	logic        source_stall;
	logic [7:0]  source_byte;
	logic        result_valid;
	logic        result_stall;
	logic        item_kind;
	logic [7:0]  value_byte;
	logic [4:0]  token_kind;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [15:0] token_length;
	logic        last_of_run;

	markup_source_tokenizer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_valid (source_valid),
		.source_stall (source_stall),
		.source_byte  (source_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.item_kind    (item_kind),
		.value_byte   (value_byte),
		.token_kind   (token_kind),
		.token_line   (token_line),
		.token_column (token_column),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Tokenizer state as this bench tracks it
	mode_t      lx_mode;
	pos_t       line_now, col_now;
	pos_t       tok_line, tok_col;
	len_t       tok_len;
	logic [2:0] kw_live;

	word_t      step_words [$];   // words caused by the byte being predicted
	word_t      words_due [$];    // words predicted and not yet received
	logic [7:0] source_text [$];  // random bytes waiting to be offered

	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_off_req = 1'b0;

	// ---------------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------------

	task automatic clear_tokenizer();
		lx_mode  = M_IDLE;
		line_now = POS_ONE;
		col_now  = POS_ONE;
		tok_line = POS_ONE;
		tok_col  = POS_ONE;
		tok_len  = '0;
		kw_live  = 3'b111;
	endtask

	function automatic pos_t bump(pos_t v);
		return v + pos_t'(v != POS_MAX);
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_name_start(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
			|| c == "_" || c == "-" || c == ".";
	endfunction

	function automatic logic [4:0] punct_code(logic [7:0] c);
		case (c)
			"{": return TK_LBRACE;
			"}": return TK_RBRACE;
			":": return TK_COLON;
			"=": return TK_EQUAL;
			";": return TK_SEMI;
			"[": return TK_LBRACK;
			"]": return TK_RBRACK;
			"@": return TK_AT;
			"+": return TK_PLUS;
			"*": return TK_STAR;
			default: return TK_UNKNOWN;
		endcase
	endfunction

	task automatic move_cursor(logic [7:0] c);
		if (c == CH_LF) begin
			line_now = bump(line_now);
			col_now  = POS_ONE;
		end else begin
			col_now = bump(col_now);
		end
	endtask

	task automatic put_word(logic ik, logic [7:0] vb, logic [4:0] tk, pos_t ln, pos_t col,
			len_t len);
		word_t w;
		w = '{ik, vb, tk, ln, col, len, 1'b0};
		step_words.push_back(w);
	endtask

	task automatic value_word(logic [7:0] c);
		put_word(IK_VALUE, c, KIND_NONE, '0, '0, '0);
		if (tok_len != LEN_MAX)
			tok_len = tok_len + len_t'(1);
	endtask

	task automatic record_word(logic [4:0] kind);
		put_word(IK_RECORD, CH_NUL, kind, tok_line, tok_col, tok_len);
	endtask

	task automatic narrow_keywords(logic [7:0] c);
		for (int i = 0; i < 3; i++)
			if (!(tok_len < kw_word[i].len() && kw_word[i][tok_len] == c))
				kw_live[i] = 1'b0;
	endtask

	task automatic start_token(mode_t m);
		tok_line = line_now;
		tok_col  = col_now;
		tok_len  = '0;
		lx_mode  = m;
	endtask

	task automatic idle_byte(logic [7:0] c);
		lx_mode = M_IDLE;
		if (c == CH_NUL) begin
			put_word(IK_RECORD, CH_NUL, TK_END, line_now, col_now, '0);
			clear_tokenizer();
		end else if (is_blank(c)) begin
			move_cursor(c);
		end else if (is_name_start(c)) begin
			start_token(M_IDENT);
			kw_live = 3'b111;
			narrow_keywords(c);
			value_word(c);
			move_cursor(c);
		end else if (c == CH_QUOTE) begin
			start_token(M_STR);
			move_cursor(c);
		end else if (c == CH_HASH) begin
			start_token(M_GFIRST);
			move_cursor(c);
		end else if (c == CH_SLASH) begin
			start_token(M_SLASH);
			move_cursor(c);
		end else begin
			put_word(IK_RECORD, c, punct_code(c), line_now, col_now, len_t'(1));
			move_cursor(c);
		end
	endtask

	task automatic comment_byte(logic [7:0] c, logic [4:0] kind);
		if (c == CH_NUL || c == CH_LF) begin
			record_word(kind);
			idle_byte(c);
		end else begin
			value_word(c);
			move_cursor(c);
		end
	endtask

	// Work out every word that one source byte causes, into step_words
	task automatic tokenize_byte(logic [7:0] c);
		logic [4:0] kind;
		word_t      w;
		step_words.delete();
		case (lx_mode)
			M_IDENT: begin
				if (is_name_start(c) || c == CH_PCT) begin
					narrow_keywords(c);
					value_word(c);
					move_cursor(c);
				end else begin
					kind = KIND_NONE;
					for (int i = 0; i < 3; i++)
						if (kind == KIND_NONE && kw_live[i] && tok_len == kw_word[i].len())
							kind = KW_KIND[i];
					record_word(kind);
					idle_byte(c);
				end
			end
			M_STR: begin
				if (c == CH_QUOTE) begin
					move_cursor(c);
					record_word(TK_STRING);
					lx_mode = M_IDLE;
				end else if (c == CH_NUL) begin
					move_cursor(c);
					record_word(TK_STRING);
					idle_byte(c);
				end else begin
					value_word(c);
					move_cursor(c);
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					move_cursor(c);
					lx_mode = M_LINEC;
				end else if (c == CH_STAR) begin
					move_cursor(c);
					lx_mode = M_BLOCK;
				end else begin
					put_word(IK_RECORD, CH_SLASH, TK_SLASH, tok_line, tok_col, len_t'(1));
					idle_byte(c);
				end
			end
			M_LINEC: comment_byte(c, TK_LINEC);
			M_GFIRST: begin
				lx_mode = M_GBODY;
				if (c == CH_SPACE)
					move_cursor(c);
				else
					comment_byte(c, TK_HASHC);
			end
			M_GBODY: comment_byte(c, TK_HASHC);
			M_BLOCK, M_BSTAR: begin
				if (lx_mode == M_BSTAR && c == CH_SLASH) begin
					move_cursor(c);
					record_word(TK_BLOCK);
					lx_mode = M_IDLE;
				end else begin
					// a held star that is not closing becomes text
					if (lx_mode == M_BSTAR)
						value_word(CH_STAR);
					if (c == CH_NUL) begin
						move_cursor(c);
						move_cursor(c);
						record_word(TK_BLOCK);
						idle_byte(c);
					end else if (c == CH_STAR) begin
						move_cursor(c);
						lx_mode = M_BSTAR;
					end else begin
						value_word(c);
						move_cursor(c);
						lx_mode = M_BLOCK;
					end
				end
			end
			default: idle_byte(c);
		endcase
		if (step_words.size() != 0) begin
			w = step_words.pop_back();
			w.last_of_run = 1'b1;
			step_words.push_back(w);
		end
	endtask

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic check_word();
		word_t w;
		if (words_due.size() == 0) begin
			report_mismatch($sformatf("word with nothing due (kind %0d, byte %0h)",
				item_kind, value_byte));
		end else begin
			w = words_due.pop_front();
			if (item_kind !== w.item_kind)
				report_mismatch($sformatf("item_kind %0d, want %0d", item_kind, w.item_kind));
			if (value_byte !== w.value_byte)
				report_mismatch($sformatf("value_byte %0h, want %0h", value_byte, w.value_byte));
			if (token_kind !== w.token_kind)
				report_mismatch($sformatf("token_kind %0d, want %0d", token_kind, w.token_kind));
			if (token_line !== w.token_line)
				report_mismatch($sformatf("token_line %0d, want %0d", token_line, w.token_line));
			if (token_column !== w.token_column)
				report_mismatch($sformatf("token_column %0d, want %0d", token_column,
					w.token_column));
			if (token_length !== w.token_length)
				report_mismatch($sformatf("token_length %0d, want %0d", token_length,
					w.token_length));
			if (last_of_run !== w.last_of_run)
				report_mismatch($sformatf("last_of_run %0d, want %0d", last_of_run,
					w.last_of_run));
		end
	endtask

	// ---------------------------------------------------------------------
	// Source side
	// ---------------------------------------------------------------------

	// Offer one byte; called and returning at a falling edge. A typed row replaces
	// the predicted word with the one written in the table.
	task automatic push_byte(logic [7:0] b, logic typed, word_t typed_word);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		repeat (gap) begin
			source_valid <= 1'b0;
			@(negedge clk);
		end
		source_valid <= 1'b1;
		source_byte  <= b;
		do @(posedge clk); while (source_stall);
		tokenize_byte(b);
		if (typed)
			words_due.push_back(typed_word);
		else
			foreach (step_words[i])
				words_due.push_back(step_words[i]);
		@(negedge clk);
	endtask

	// Drop valid and hold until every predicted word has come back
	task automatic drain();
		source_valid <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] name_char(bit allow_pct);
		if (allow_pct && $urandom_range(0, 9) == 0)
			return CH_PCT;
		return name_chars[$urandom_range(0, name_chars.len() - 1)];
	endfunction

	function automatic logic [7:0] text_byte(logic [7:0] banned);
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255)); while (b == banned);
		return b;
	endfunction

	// Append one random fragment: mostly well-formed tokens with random content,
	// the rest noise, broken tokens and end-of-input bytes
	task automatic add_fragment();
		int    pick;
		int    n;
		string kw;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// keyword, sometimes cut short or run on into an identifier
			kw = kw_word[$urandom_range(0, 2)];
			n  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, kw.len()) : kw.len();
			for (int i = 0; i < n; i++)
				source_text.push_back(kw[i]);
			if ($urandom_range(0, 3) == 0)
				source_text.push_back(name_char(1'b1));
		end else if (pick < 30) begin
			source_text.push_back(name_char(1'b0));
			repeat ($urandom_range(0, 5))
				source_text.push_back(name_char(1'b1));
		end else if (pick < 42) begin
			source_text.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 5))
				source_text.push_back(text_byte(CH_QUOTE));
			if ($urandom_range(0, 5) != 0)
				source_text.push_back(CH_QUOTE);
		end else if (pick < 52) begin
			source_text.push_back(CH_SLASH);
			source_text.push_back(CH_SLASH);
			repeat ($urandom_range(0, 5))
				source_text.push_back(text_byte(CH_LF));
			source_text.push_back(CH_LF);
		end else if (pick < 62) begin
			source_text.push_back(CH_SLASH);
			source_text.push_back(CH_STAR);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 3))
					0: source_text.push_back(CH_STAR);
					1: source_text.push_back(CH_SLASH);
					default: source_text.push_back(text_byte(CH_STAR));
				endcase
			end
			if ($urandom_range(0, 5) != 0) begin
				source_text.push_back(CH_STAR);
				source_text.push_back(CH_SLASH);
			end
		end else if (pick < 70) begin
			source_text.push_back(CH_HASH);
			if ($urandom_range(0, 1))
				source_text.push_back(CH_SPACE);
			repeat ($urandom_range(0, 4))
				source_text.push_back(text_byte(CH_LF));
			source_text.push_back(CH_LF);
		end else if (pick < 82) begin
			source_text.push_back(PUNCT[$urandom_range(0, 11)]);
		end else if (pick < 94) begin
			source_text.push_back(8'($urandom_range(1, 255)));
		end else if (pick < 97) begin
			source_text.push_back(CH_NUL);
		end else begin
			repeat ($urandom_range(2, 6))
				source_text.push_back(BLANKS[$urandom_range(0, 5)]);
		end
		if ($urandom_range(0, 1))
			source_text.push_back(BLANKS[$urandom_range(0, 5)]);
	endtask

	// ---------------------------------------------------------------------
	// Stimulus: reset, directed table, random text, wrap-up
	// ---------------------------------------------------------------------

	initial begin : source_side
		int         counted;
		bit         hold_done;
		logic [7:0] b;
		counted   = 0;
		hold_done = 1'b0;
		arst_n       = 1'b0;
		source_valid = 1'b0;
		source_byte  = CH_NUL;
		clear_tokenizer();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (DIRECTED_ROWS[i])
			push_byte(DIRECTED_ROWS[i].src, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		// Pause until the block has emptied
		drain();

		// Random text; flip the idling of either side now and then so that some
		// stretches run flat out
		while (counted < RANDOM_ITEMS) begin
			add_fragment();
			if ($urandom_range(0, 7) == 0)
				tx_idle = !tx_idle;
			if ($urandom_range(0, 7) == 0)
				rx_idle = !rx_idle;
			if (!hold_done && counted >= RANDOM_ITEMS / 2) begin
				// keep offering while the receiver holds off, so the block backs up
				hold_done    = 1'b1;
				tx_idle      = 1'b0;
				hold_off_req = 1'b1;
				repeat (6) add_fragment();
			end
			while (source_text.size() != 0) begin
				b = source_text.pop_front();
				counted++;
				push_byte(b, 1'b0, NO_WORD);
			end
		end
		push_byte(CH_NUL, 1'b0, NO_WORD);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Result side: while idling, stall a random number of cycles before each word, or hold
	// off for a long stretch once when asked
	// ---------------------------------------------------------------------

	initial begin : result_side
		int wait_n;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			wait_n = rx_idle ? $urandom_range(0, 11) : 0;
			if (hold_off_req) begin
				wait_n       = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			repeat (wait_n) begin
				result_stall <= 1'b1;
				@(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			check_word();
			@(negedge clk);
		end
	end

	// Watchdog: count edges at which neither channel moves a word
	always @(posedge clk) begin
		if (!arst_n || (source_valid && !source_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no word moved for %0d cycles, %0d still due", quiet_cycles,
				words_due.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule
